[design/nsc_pkg.sv]
// Shared types, character codes and helpers for the NMEA sentence checker.
// No dependencies; compiled first.
`default_nettype none
package nsc_pkg;

   localparam int BYTE_W  = 8;
   localparam int COUNT_W = 6;
   localparam int KIND_W  = 2;
   localparam int CSR_IDX_W = 1;

   localparam logic [BYTE_W-1:0] CH_START   = 8'h24;
   localparam logic [BYTE_W-1:0] CH_NEWLINE = 8'h0A;
   localparam logic [BYTE_W-1:0] CH_STAR    = 8'h2A;
   localparam logic [BYTE_W-1:0] CH_COMMA   = 8'h2C;

   localparam logic [BYTE_W-1:0] FIRST_KIND_RESET  = 8'h50;  // 'P'
   localparam logic [BYTE_W-1:0] SECOND_KIND_RESET = 8'h54;  // 'T'

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   // register indexes on the csr port
   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_KIND  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_SECOND_KIND = 1'b1;

   typedef enum logic [KIND_W-1:0] {
      KIND_OTHER  = 2'd0,
      KIND_FIRST  = 2'd1,
      KIND_SECOND = 2'd2
   } kind_type;

   typedef struct packed {
      logic                checksum_ok;
      logic                sum_present;
      kind_type            sentence_kind;
      logic [COUNT_W-1:0]  field_count;
      logic [BYTE_W-1:0]   computed_sum;
      logic [BYTE_W-1:0]   received_sum;
   } result_type;

   // {invalid, nibble}: uppercase hex digit decode
   function automatic logic [4:0] hex_decode(input logic [BYTE_W-1:0] c);
      logic [4:0] r;
      r = 5'h10;
      if (c >= 8'h30 && c <= 8'h39) begin
         r = {1'b0, c[3:0]};
      end else if (c >= 8'h41 && c <= 8'h46) begin
         r = {1'b0, c[3:0] + 4'd9};
      end
      return r;
   endfunction

endpackage
`default_nettype wire

[design/nsc_channels.sv]
// Valid/ready channel interfaces for the checker's byte input and result output.
// Depends on nsc_pkg.
`default_nettype none
interface nsc_req_if;
   logic                       valid;
   logic                       ready;
   logic [nsc_pkg::BYTE_W-1:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface nsc_rsp_if;
   logic                        valid;
   logic                        ready;
   logic                        checksum_ok;
   logic                        sum_present;
   logic [nsc_pkg::KIND_W-1:0]  sentence_kind;
   logic [nsc_pkg::COUNT_W-1:0] field_count;
   logic [nsc_pkg::BYTE_W-1:0]  computed_sum;
   logic [nsc_pkg::BYTE_W-1:0]  received_sum;

   modport source (output valid, output checksum_ok, output sum_present,
                   output sentence_kind, output field_count, output computed_sum,
                   output received_sum, input ready);
   modport sink   (input valid, input checksum_ok, input sum_present,
                   input sentence_kind, input field_count, input computed_sum,
                   input received_sum, output ready);
endinterface
`default_nettype wire

[design/nsc_tracker.sv]
// Sentence state machine: start hunt, XOR/comma accumulation, kind and digit capture.
// Depends on nsc_pkg.
`default_nettype none
module nsc_tracker (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       step,
   input  wire logic [nsc_pkg::BYTE_W-1:0] rx_byte,
   input  wire logic [nsc_pkg::BYTE_W-1:0] first_letter,
   input  wire logic [nsc_pkg::BYTE_W-1:0] second_letter,
   output logic                            emit,
   output nsc_pkg::result_type             result
);
   import nsc_pkg::*;

   typedef enum logic [2:0] {
      PH_HUNT  = 3'd0,
      PH_BODY  = 3'd1,
      PH_DIG1  = 3'd2,
      PH_DIG2  = 3'd3,
      PH_AFTER = 3'd4
   } phase_type;

   phase_type           phase_ff;
   logic [BYTE_W-1:0]   xor_ff;
   logic [1:0]          pos_ff;
   kind_type            kind_ff;
   logic [COUNT_W-1:0]  comma_ff;
   logic [BYTE_W-1:0]   digits_ff;
   logic                dvalid_ff;

   logic                in_sentence;
   logic [4:0]          hex;

   assign in_sentence = (phase_ff != PH_HUNT);
   assign emit = in_sentence && (rx_byte == CH_NEWLINE);
   assign hex  = hex_decode(rx_byte);

   always_comb begin
      result.sum_present   = dvalid_ff;
      result.checksum_ok   = dvalid_ff && (digits_ff == xor_ff);
      result.sentence_kind = kind_ff;
      result.field_count   = (comma_ff == COUNT_MAX) ? COUNT_MAX : comma_ff + 1'b1;
      result.computed_sum  = xor_ff;
      result.received_sum  = dvalid_ff ? digits_ff : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HUNT;
         xor_ff    <= '0;
         pos_ff    <= '0;
         kind_ff   <= KIND_OTHER;
         comma_ff  <= '0;
         digits_ff <= '0;
         dvalid_ff <= 1'b0;
      end else if (step) begin
         if (rx_byte == CH_START || emit) begin
            phase_ff  <= (rx_byte == CH_START) ? PH_BODY : PH_HUNT;
            xor_ff    <= '0;
            pos_ff    <= '0;
            kind_ff   <= KIND_OTHER;
            comma_ff  <= '0;
            digits_ff <= '0;
            dvalid_ff <= 1'b0;
         end else begin
            case (phase_ff)
               PH_BODY: begin
                  if (pos_ff == 2'd1) begin
                     if (rx_byte == first_letter) begin
                        kind_ff <= KIND_FIRST;
                     end else if (rx_byte == second_letter) begin
                        kind_ff <= KIND_SECOND;
                     end else begin
                        kind_ff <= KIND_OTHER;
                     end
                  end
                  if (pos_ff != 2'd3) begin
                     pos_ff <= pos_ff + 2'd1;
                  end
                  if (rx_byte == CH_STAR) begin
                     phase_ff <= PH_DIG1;
                  end else begin
                     xor_ff <= xor_ff ^ rx_byte;
                     if (rx_byte == CH_COMMA && comma_ff != COUNT_MAX) begin
                        comma_ff <= comma_ff + 1'b1;
                     end
                  end
               end
               PH_DIG1: begin
                  if (!hex[4]) begin
                     digits_ff <= {hex[3:0], 4'h0};
                     phase_ff  <= PH_DIG2;
                  end else begin
                     digits_ff <= '0;
                     phase_ff  <= PH_AFTER;
                  end
               end
               PH_DIG2: begin
                  if (!hex[4]) begin
                     digits_ff <= {digits_ff[7:4], hex[3:0]};
                     dvalid_ff <= 1'b1;
                  end else begin
                     digits_ff <= '0;
                  end
                  phase_ff <= PH_AFTER;
               end
               PH_AFTER: begin
                  phase_ff <= PH_AFTER;  // trailing bytes ignored until newline
               end
               default: begin
                  phase_ff <= PH_HUNT;
               end
            endcase
         end
      end
   end

endmodule
`default_nettype wire

[design/nsc_result_reg.sv]
// Output register for one sentence result, drives the response channel.
// Depends on nsc_pkg and nsc_rsp_if.
`default_nettype none
module nsc_result_reg (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                load,
   input  wire nsc_pkg::result_type result,
   nsc_rsp_if.source                rsp_ch
);
   import nsc_pkg::*;

   logic       valid_ff;
   result_type data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= result;
      end
   end

   assign rsp_ch.valid         = valid_ff;
   assign rsp_ch.checksum_ok   = data_ff.checksum_ok;
   assign rsp_ch.sum_present   = data_ff.sum_present;
   assign rsp_ch.sentence_kind = data_ff.sentence_kind;
   assign rsp_ch.field_count   = data_ff.field_count;
   assign rsp_ch.computed_sum  = data_ff.computed_sum;
   assign rsp_ch.received_sum  = data_ff.received_sum;

endmodule
`default_nettype wire

[design/nmea_sentence_checker_unit.sv]
// Top level of the NMEA 0183 sentence checksum checker.
// Depends on nsc_pkg, nsc_channels, nsc_tracker and nsc_result_reg.
//
// Usage:
//  - req_ch carries one received serial byte per item (valid/ready).
//  - rsp_ch carries one result item per newline that closes a sentence:
//    checksum match, sum present, kind, field count, computed and received sums.
//  - csr_write_enable/csr_index/csr_write_data set the two kind letters
//    (index 0: first kind, reset 'P'; index 1: second kind, reset 'T').
//    Write them only while the block is idle.
// Timing:
//  - A byte is captured and held in the input register, then the sentence
//    tracker updates and, on a closing newline, loads the result register.
//  - Throughput: one byte per cycle, unless a closing newline waits on a
//    stalled result (see Stall).
// Reset (synchronous): tracker hunts for '$', both pipeline registers empty,
//  kind letters back to 'P' and 'T'.
// Stall: while a result waits on rsp_ch, other bytes keep flowing; a closing
//  newline waits in the input register and req ready stays low until the
//  waiting result is taken.
`default_nettype none
module nmea_sentence_checker_unit (
   input  wire logic                          clock,
   input  wire logic                          reset,
   nsc_req_if.sink                            req_ch,
   nsc_rsp_if.source                          rsp_ch,
   input  wire logic                          csr_write_enable,
   input  wire logic [nsc_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [nsc_pkg::BYTE_W-1:0]    csr_write_data
);
   import nsc_pkg::*;

   // kind letter registers
   logic [BYTE_W-1:0] first_letter_ff;
   logic [BYTE_W-1:0] second_letter_ff;

   // input register
   logic              in_valid_ff;
   logic [BYTE_W-1:0] in_byte_ff;

   logic              emit;
   logic              advance;
   logic              load;
   result_type        result;

   always_ff @(posedge clock) begin
      if (reset) begin
         first_letter_ff  <= FIRST_KIND_RESET;
         second_letter_ff <= SECOND_KIND_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_FIRST_KIND:  first_letter_ff  <= csr_write_data;
            CSR_SECOND_KIND: second_letter_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   // A held byte moves on unless it closes a sentence and the result slot is busy.
   assign advance = in_valid_ff && (!emit || !rsp_ch.valid || rsp_ch.ready);
   assign load    = advance && emit;
   assign req_ch.ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         in_valid_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         in_byte_ff <= req_ch.rx_byte;
      end
   end

   nsc_tracker u_tracker (
      .clock         (clock),
      .reset         (reset),
      .step          (advance),
      .rx_byte       (in_byte_ff),
      .first_letter  (first_letter_ff),
      .second_letter (second_letter_ff),
      .emit          (emit),
      .result        (result)
   );

   nsc_result_reg u_result (
      .clock  (clock),
      .reset  (reset),
      .load   (load),
      .result (result),
      .rsp_ch (rsp_ch)
   );

   // never overwrite a result the receiver has not taken
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && !rsp_ch.ready) |-> !load)
      else $error("result register overwritten while stalled");

   // a result only comes from a closing newline
   a_load_newline: assert property (@(posedge clock) disable iff (reset)
      load |-> (in_byte_ff == CH_NEWLINE))
      else $error("result loaded on a non-newline byte");

   // a matching checksum needs captured digits; absent digits read as zero
   a_ok_needs_sum: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> ((!rsp_ch.checksum_ok || rsp_ch.sum_present)
                        && (rsp_ch.sum_present || rsp_ch.received_sum == '0)))
      else $error("inconsistent checksum fields");

   // back pressure only while a byte is held
   a_ready_low: assert property (@(posedge clock) disable iff (reset)
      !req_ch.ready |-> (in_valid_ff && emit && rsp_ch.valid))
      else $error("input stalled without cause");

endmodule
`default_nettype wire

[dv/tb_nmea_sentence_checker_unit.sv]
// Testbench for nmea_sentence_checker_unit: byte stream in, sentence reports out.
// Uses nsc_pkg and the nsc_req_if / nsc_rsp_if channel interfaces from the design.
// Self-checking: a bench tracker, or a typed row, predicts every report in order.
`timescale 1ns / 100ps

module tb_nmea_sentence_checker_unit;
   import nsc_pkg::*;

   localparam int STALL_LIMIT   = 2000;  // cycles with no item moving on either side
   localparam int HOLD_CYCLES   = 64;    // long receiver hold-off, fills the block
   localparam int DRAIN_CYCLES  = 4;     // settling margin after the last report is taken
   localparam int PHASE_BYTES   = 110;
   localparam int PHASE_REPORTS = 7;
   localparam int DIR_ROWS      = 6;

   localparam logic [BYTE_W-1:0] CH_RETURN = 8'h0D;

   // where the bench's tracker is inside a sentence
   typedef enum logic [2:0] {
      SCAN_HUNT,
      SCAN_BODY,
      SCAN_DIGIT_HI,
      SCAN_DIGIT_LO,
      SCAN_TRAIL
   } scan_phase_type;

   logic clock;
   logic reset;
   logic                 csr_write_enable;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [BYTE_W-1:0]    csr_write_data;

   nsc_req_if req_ch ();
   nsc_rsp_if rsp_ch ();

   nmea_sentence_checker_unit uut (
      .clock            (clock),
      .reset            (reset),
      .req_ch           (req_ch),
      .rsp_ch           (rsp_ch),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always #1 clock = ~clock;

   // ---------------------------------------------------------------------
   // Bench copy of the kind letters and the sentence tracker state
   // ---------------------------------------------------------------------
   logic [BYTE_W-1:0]  first_letter;
   logic [BYTE_W-1:0]  second_letter;

   scan_phase_type     scan_phase;
   logic [BYTE_W-1:0]  sum_so_far;
   logic [1:0]         body_count;
   kind_type           kind_so_far;
   logic [COUNT_W-1:0] comma_count;
   logic [BYTE_W-1:0]  digits_seen;
   logic               digits_good;

   result_type sentence_reports_due[$];

   // directed rows: '~' stands for byte 0xFF and '_' for byte 0x00
   string      dir_text   [DIR_ROWS];
   bit         dir_typed  [DIR_ROWS];
   result_type dir_expect [DIR_ROWS];

   // a typed-in report overrides the tracker for the row being sent
   bit         typed_armed;
   result_type typed_value;

   bit idle_on;
   int hold_requests;
   int holds_done;
   int bytes_sent;
   int reports_predicted;
   int mismatches;
   int quiet_cycles;

   function automatic void clear_sentence();
      sum_so_far  = '0;
      body_count  = '0;
      kind_so_far = KIND_OTHER;
      comma_count = '0;
      digits_seen = '0;
      digits_good = 1'b0;
   endfunction

   // uppercase hex only; lowercase counts as a bad digit
   function automatic bit hex_upper(input logic [BYTE_W-1:0] c, output logic [3:0] nib);
      nib = '0;
      if (c >= "0" && c <= "9") begin
         nib = 4'(c - 8'h30);
         return 1'b1;
      end
      if (c >= "A" && c <= "F") begin
         nib = 4'(c - 8'h37);
         return 1'b1;
      end
      return 1'b0;
   endfunction

   // Advance the tracker by one byte; returns 1 when a newline closes a sentence.
   function automatic bit track_nmea_byte(input logic [BYTE_W-1:0] c, output result_type rpt);
      logic [3:0] nib;
      rpt = '0;
      // '$' always opens a fresh sentence, dropping any open one
      if (c == CH_START) begin
         clear_sentence();
         scan_phase = SCAN_BODY;
         return 1'b0;
      end
      if (scan_phase == SCAN_HUNT)
         return 1'b0;
      if (c == CH_NEWLINE) begin
         rpt.sum_present   = digits_good;
         rpt.checksum_ok   = digits_good && (digits_seen == sum_so_far);
         rpt.sentence_kind = kind_so_far;
         rpt.field_count   = (comma_count == COUNT_MAX) ? COUNT_MAX : comma_count + 6'd1;
         rpt.computed_sum  = sum_so_far;
         rpt.received_sum  = digits_good ? digits_seen : '0;
         scan_phase = SCAN_HUNT;
         clear_sentence();
         return 1'b1;
      end
      case (scan_phase)
         SCAN_BODY: begin
            // second byte after '$' picks the kind, whatever it is; first letter wins a tie
            if (body_count == 2'd1) begin
               if (c == first_letter)
                  kind_so_far = KIND_FIRST;
               else if (c == second_letter)
                  kind_so_far = KIND_SECOND;
               else
                  kind_so_far = KIND_OTHER;
            end
            if (body_count != 2'd3)
               body_count++;
            if (c == CH_STAR) begin
               scan_phase = SCAN_DIGIT_HI;
            end else begin
               sum_so_far ^= c;
               if (c == CH_COMMA && comma_count != COUNT_MAX)
                  comma_count++;
            end
         end
         SCAN_DIGIT_HI: begin
            if (hex_upper(c, nib)) begin
               digits_seen = {nib, 4'h0};
               scan_phase  = SCAN_DIGIT_LO;
            end else begin
               digits_seen = '0;
               scan_phase  = SCAN_TRAIL;
            end
         end
         SCAN_DIGIT_LO: begin
            if (hex_upper(c, nib)) begin
               digits_seen[3:0] = nib;
               digits_good      = 1'b1;
            end else begin
               digits_seen = '0;
            end
            scan_phase = SCAN_TRAIL;
         end
         default: ;  // trailing bytes up to the newline are ignored
      endcase
      return 1'b0;
   endfunction

   function automatic logic [BYTE_W-1:0] hex_char(input logic [3:0] n);
      return (n < 4'd10) ? 8'h30 + {4'h0, n} : 8'h37 + {4'h0, n};
   endfunction

   // random sentence body byte: anything but the three framing characters
   function automatic logic [BYTE_W-1:0] body_char();
      logic [BYTE_W-1:0] b;
      do
         b = 8'($urandom_range(0, 255));
      while (b == CH_START || b == CH_STAR || b == CH_NEWLINE);
      return b;
   endfunction

   // ---------------------------------------------------------------------
   // Byte sender: optional idle burst, then hold valid until accepted.
   // Prediction runs here, at the edge of acceptance.
   // ---------------------------------------------------------------------
   task automatic send_byte(input logic [BYTE_W-1:0] value);
      result_type rpt;
      if (idle_on && $urandom_range(0, 4) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.rx_byte <= value;
      do @(posedge clock); while (!req_ch.ready);
      bytes_sent++;
      if (track_nmea_byte(value, rpt)) begin
         reports_predicted++;
         sentence_reports_due = {sentence_reports_due, typed_armed ? typed_value : rpt};
      end
   endtask

   // Mostly well-formed sentences with random content; some noise, some cut short.
   task automatic send_random_sentence();
      logic [BYTE_W-1:0] sum;
      logic [BYTE_W-1:0] b;
      logic [BYTE_W-1:0] digits;
      int style;
      int tail;
      int len;
      bit wide;
      style = $urandom_range(0, 99);
      if (style < 8) begin
         // raw noise, any byte value, may hold stray '$' or newline
         repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
         return;
      end
      // a rare long sentence of commas drives the field count into saturation
      wide = ($urandom_range(0, 19) == 0);
      len  = wide ? $urandom_range(64, 90) : $urandom_range(0, 12);
      sum  = '0;
      send_byte(CH_START);
      for (int i = 0; i < len; i++) begin
         if (i == 1) begin
            case ($urandom_range(0, 2))
               0:       b = first_letter;
               1:       b = second_letter;
               default: b = body_char();
            endcase
         end else if (wide || $urandom_range(0, 3) == 0) begin
            b = CH_COMMA;
         end else begin
            b = body_char();
         end
         sum ^= b;
         send_byte(b);
      end
      // cut short: no newline here; a later '$' drops it, unless a noise newline closes it
      if (style < 14)
         return;
      tail = $urandom_range(0, 9);
      if (tail < 9) begin
         send_byte(CH_STAR);
         digits = (tail == 6) ? sum ^ 8'($urandom_range(1, 255)) : sum;
         if (tail == 7)
            send_byte(8'($urandom_range(0, 255)));
         else
            send_byte(hex_char(digits[7:4]));
         // tail 8: the second digit is left out
         if (tail == 5)
            send_byte(8'($urandom_range(0, 255)));
         else if (tail != 8)
            send_byte(hex_char(digits[3:0]));
         if ($urandom_range(0, 2) == 0)
            send_byte(CH_RETURN);
         if ($urandom_range(0, 5) == 0)
            send_byte(CH_STAR);
      end
      // tail 9: no star at all
      send_byte(CH_NEWLINE);
   endtask

   // Park the sender and wait for every predicted report to come out.
   task automatic drain();
      req_ch.valid <= 1'b0;
      while (sentence_reports_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Idle the block, load both kind letters, then stream random sentences.
   task automatic run_phase(input logic [BYTE_W-1:0] first, input logic [BYTE_W-1:0] second,
                            input bit squeeze);
      int start_bytes;
      int start_reports;
      drain();
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_FIRST_KIND;
      csr_write_data   <= first;
      @(posedge clock);
      csr_index        <= CSR_SECOND_KIND;
      csr_write_data   <= second;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      first_letter  = first;
      second_letter = second;
      if (squeeze)
         hold_requests++;
      start_bytes   = bytes_sent;
      start_reports = reports_predicted;
      while (bytes_sent - start_bytes < PHASE_BYTES ||
             reports_predicted - start_reports < PHASE_REPORTS)
         send_random_sentence();
   endtask

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin
      logic [BYTE_W-1:0] c;
      clock = 1'b0;
      reset <= 1'b1;
      req_ch.valid     <= 1'b0;
      req_ch.rx_byte   <= '0;
      csr_write_enable <= 1'b0;
      csr_index        <= CSR_FIRST_KIND;
      csr_write_data   <= '0;
      idle_on           = 1'b1;
      typed_armed       = 1'b0;
      typed_value       = '0;
      hold_requests     = 0;
      bytes_sent        = 0;
      reports_predicted = 0;
      first_letter      = FIRST_KIND_RESET;
      second_letter     = SECOND_KIND_RESET;
      scan_phase        = SCAN_HUNT;
      clear_sentence();

      // stray byte and newline while hunting: dropped
      dir_text[0] = "Z\n";
      dir_typed[0] = 1'b0;
      dir_expect[0] = '0;
      // empty sentence
      dir_text[1] = "$\n";
      dir_typed[1] = 1'b1;
      dir_expect[1] = {1'b0, 1'b0, KIND_OTHER, 6'd1, 8'h00, 8'h00};
      // good checksum, reset first letter 'P' in kind position
      dir_text[2] = "$AP*11\n";
      dir_typed[2] = 1'b1;
      dir_expect[2] = {1'b1, 1'b1, KIND_FIRST, 6'd1, 8'h11, 8'h11};
      // restart on second '$', 'T' kind, one comma, wrong sum, CR after digits
      dir_text[3] = "$$ZT,*FF\015\n";
      dir_typed[3] = 1'b0;
      dir_expect[3] = '0;
      // star in kind position, non-hex first digit 'G'
      dir_text[4] = "$A*G0\n";
      dir_typed[4] = 1'b1;
      dir_expect[4] = {1'b0, 1'b0, KIND_OTHER, 6'd1, 8'h41, 8'h00};
      // extreme byte values in the body, newline after only one digit
      dir_text[5] = "$~_*9\n";
      dir_typed[5] = 1'b0;
      dir_expect[5] = '0;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      for (int row = 0; row < DIR_ROWS; row++) begin
         typed_armed = dir_typed[row];
         typed_value = dir_expect[row];
         for (int i = 0; i < dir_text[row].len(); i++) begin
            c = dir_text[row][i];
            if (c == "~")
               c = 8'hFF;
            else if (c == "_")
               c = 8'h00;
            send_byte(c);
         end
      end
      typed_armed = 1'b0;

      // kind letter settings: ordinary, extremes, a tie, then high byte and comma
      run_phase("G", "R", 1'b1);
      run_phase(8'h00, 8'hFF, 1'b0);
      run_phase("A", "A", 1'b1);
      idle_on = 1'b0;   // last stretch runs at full rate on both sides
      run_phase(8'hFF, CH_COMMA, 1'b0);
      drain();

      if (mismatches == 0 && sentence_reports_due.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Report receiver: random stalls, and a long hold-off on request so the
   // block backs up and drops req ready.
   // ---------------------------------------------------------------------
   initial begin
      holds_done = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_requests != holds_done) begin
            holds_done++;
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else if (idle_on && $urandom_range(0, 4) == 0) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(0, 6)) @(posedge clock);
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Report checker: in-order compare against the oldest prediction
   // ---------------------------------------------------------------------
   initial mismatches = 0;

   always @(posedge clock) begin
      result_type want;
      result_type got;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got = {rsp_ch.checksum_ok, rsp_ch.sum_present, kind_type'(rsp_ch.sentence_kind),
                rsp_ch.field_count, rsp_ch.computed_sum, rsp_ch.received_sum};
         if (sentence_reports_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display({"%0t: report with none due: ",
                         "ok=%0d sum=%0d kind=%0d fields=%0d calc=%h rcvd=%h"},
                        $time, got.checksum_ok, got.sum_present, got.sentence_kind,
                        got.field_count, got.computed_sum, got.received_sum);
         end else begin
            want = sentence_reports_due.pop_front();
            if (got.checksum_ok   !== want.checksum_ok   ||
                got.sum_present   !== want.sum_present   ||
                got.sentence_kind !== want.sentence_kind ||
                got.field_count   !== want.field_count   ||
                got.computed_sum  !== want.computed_sum  ||
                got.received_sum  !== want.received_sum) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"%0t: expected ok=%0d sum=%0d kind=%0d fields=%0d ",
                            "calc=%h rcvd=%h, got ok=%0d sum=%0d kind=%0d ",
                            "fields=%0d calc=%h rcvd=%h"},
                           $time, want.checksum_ok, want.sum_present, want.sentence_kind,
                           want.field_count, want.computed_sum, want.received_sum,
                           got.checksum_ok, got.sum_present, got.sentence_kind,
                           got.field_count, got.computed_sum, got.received_sum);
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Watchdog: too long with no item moving on either channel ends the run
   // ---------------------------------------------------------------------
   initial quiet_cycles = 0;

   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

endmodule
